>>> design/dltq_pkg.sv
// Package with the shared types, codes and defaults of the delta-list timer queue.
package dltq_pkg;

    localparam int DLTQ_ID_W       = 4;
    localparam int DLTQ_DELAY_W    = 32;
    localparam int DLTQ_IDS        = 1 << DLTQ_ID_W;
    localparam int DEF_NUM_TIMERS  = 16;
    localparam int DEF_TICK_WIDTH  = 32;

    // Input actions.
    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_CANCEL = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;
    localparam logic [1:0] ACT_QUERY  = 2'd3;

    // Result kinds.
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_ERR   = 2'd3;

    // Operations broadcast to every cell of the chain.
    typedef logic [2:0] op_t;
    localparam op_t OP_NOP     = 3'd0;
    localparam op_t OP_INSERT  = 3'd1;
    localparam op_t OP_CANCEL  = 3'd2;
    localparam op_t OP_DECR    = 3'd3;
    localparam op_t OP_POP     = 3'd4;
    localparam op_t OP_COMPACT = 3'd5;

    typedef struct packed {
        op_t                  op;
        logic [DLTQ_ID_W-1:0] id;
    } dltq_cmd_t;

    typedef struct packed {
        logic [1:0]              action;
        logic [DLTQ_ID_W-1:0]    timer_id;
        logic [DLTQ_DELAY_W-1:0] delay;
        logic                    repeat_req;
    } dltq_in_t;

    typedef struct packed {
        logic [1:0]              kind;
        logic [DLTQ_ID_W-1:0]    timer_id_res;
        logic [DLTQ_DELAY_W-1:0] remaining;
        logic                    running;
        logic                    last;
    } dltq_out_t;

endpackage

>>> design/dltq_in_if.sv
// Interface of the command channel: valid, ready and one command transaction.
interface dltq_in_if import dltq_pkg::*;;
    logic     valid;
    logic     ready;
    dltq_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/dltq_out_if.sv
// Interface of the result channel: valid, ready and one result transaction.
interface dltq_out_if import dltq_pkg::*;;
    logic      valid;
    logic      ready;
    dltq_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/dltq_cell.sv
// One queue cell: holds one timer entry with its absolute remaining ticks.
module dltq_cell import dltq_pkg::*;
#(
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dltq_cmd_t             cmd,
    input  logic [TICK_WIDTH-1:0] ins_t,
    input  logic [TICK_WIDTH-1:0] ins_rld,
    input  logic                  left_valid,
    input  logic                  left_cond,
    input  logic                  left_hole,
    input  logic [DLTQ_ID_W-1:0]  left_id,
    input  logic [TICK_WIDTH-1:0] left_rem,
    input  logic [TICK_WIDTH-1:0] left_rld,
    input  logic [TICK_WIDTH-1:0] left_acc,
    input  logic                  right_valid,
    input  logic [DLTQ_ID_W-1:0]  right_id,
    input  logic [TICK_WIDTH-1:0] right_rem,
    input  logic [TICK_WIDTH-1:0] right_rld,
    output logic                  valid,
    output logic                  cond,
    output logic                  hole,
    output logic [DLTQ_ID_W-1:0]  id,
    output logic [TICK_WIDTH-1:0] rem,
    output logic [TICK_WIDTH-1:0] rld,
    output logic [TICK_WIDTH-1:0] acc
);

    logic                  valid_reg, valid_next;
    logic                  hole_reg, hole_next;
    logic [DLTQ_ID_W-1:0]  id_reg, id_next;
    logic [TICK_WIDTH-1:0] rem_reg, rem_next;
    logic [TICK_WIDTH-1:0] rld_reg, rld_next;
    logic [TICK_WIDTH-1:0] acc_reg, acc_next;
    logic                  match;

    // The new entry goes here or further left when this cell is empty or not earlier.
    assign cond  = !valid_reg || (rem_reg >= ins_t);
    assign match = valid_reg && (id_reg == cmd.id);

    // Next cell contents for the broadcast operation.
    always_comb
    begin
        valid_next = valid_reg;
        hole_next  = hole_reg;
        id_next    = id_reg;
        rem_next   = rem_reg;
        rld_next   = rld_reg;
        unique case (cmd.op)
            OP_INSERT:
            begin
                if (left_cond)
                begin
                    valid_next = left_valid;
                    id_next    = left_id;
                    rem_next   = left_rem;
                    rld_next   = left_rld;
                end
                else if (cond)
                begin
                    valid_next = 1'b1;
                    id_next    = cmd.id;
                    rem_next   = ins_t;
                    rld_next   = ins_rld;
                end
            end
            OP_CANCEL:
            begin
                if (match)
                begin
                    valid_next = 1'b0;
                    hole_next  = 1'b1;
                end
            end
            OP_DECR:
            begin
                if (valid_reg)
                begin
                    rem_next = rem_reg - TICK_WIDTH'(1);
                end
            end
            OP_POP:
            begin
                valid_next = right_valid;
                id_next    = right_id;
                rem_next   = right_rem;
                rld_next   = right_rld;
            end
            OP_COMPACT:
            begin
                // A hole pulls its right neighbor in and moves one cell right.
                if (hole_reg)
                begin
                    valid_next = right_valid;
                    id_next    = right_id;
                    rem_next   = right_rem;
                    rld_next   = right_rld;
                    hole_next  = 1'b0;
                end
                else if (left_hole && valid_reg)
                begin
                    valid_next = 1'b0;
                    hole_next  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Query result travels right one cell a cycle.
    assign acc_next = match ? rem_reg : left_acc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hole_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hole_reg  <= hole_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        rem_reg <= rem_next;
        rld_reg <= rld_next;
        acc_reg <= acc_next;
    end

    assign valid = valid_reg;
    assign hole  = hole_reg;
    assign id    = id_reg;
    assign rem   = rem_reg;
    assign rld   = rld_reg;
    assign acc   = acc_reg;

endmodule

>>> design/delta_list_timer_queue_top.sv
// Top level of the delta-list timer queue: command sequencer over a chain of queue cells.
//
//   Channel   Direction  Transaction
//   in_ch     sink       action, timer_id, delay, repeat_req
//   out_ch    source     kind, timer_id_res, remaining, running, last
//
// Start goes from S_EXEC straight to its result; cancel of a running timer and query
// first pass through S_WAIT for the one-cell-per-cycle compaction and answer shift.
// A tick with nothing expired gives no result; otherwise each fired timer passes
// through S_FIRE (check and pop), S_REIN (reinsert), S_LAST and S_OUT (result).
// One command is handled at a time; a stalled result holds the block until it is taken.
// Reset empties the queue at once: every cell valid bit and all timer flags clear.
module delta_list_timer_queue_top import dltq_pkg::*;
#(
    parameter int NUM_TIMERS = DEF_NUM_TIMERS,
    parameter int TICK_WIDTH = DEF_TICK_WIDTH
)
(
    input logic       clk,
    input logic       rst_n,
    dltq_in_if.sink   in_ch,
    dltq_out_if.source out_ch
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WAIT = 3'd2;
    localparam logic [2:0] S_FIRE = 3'd3;
    localparam logic [2:0] S_REIN = 3'd4;
    localparam logic [2:0] S_LAST = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DLTQ_IDS-1:0]   active_reg, active_next;
    logic [1:0]            action_reg, action_next;
    logic [DLTQ_ID_W-1:0]  id_reg, id_next;
    logic [TICK_WIDTH-1:0] t_reg, t_next;
    logic [TICK_WIDTH-1:0] rld_reg, rld_next;
    dltq_out_t             res_reg, res_next;
    dltq_cmd_t             cmd;
    logic                  id_ok;
    logic [TICK_WIDTH-1:0] in_t;

    logic [NUM_TIMERS-1:0] valid_vec;
    logic [NUM_TIMERS-1:0] cond_vec;
    logic [NUM_TIMERS-1:0] hole_vec;
    logic [DLTQ_ID_W-1:0]  id_w  [NUM_TIMERS];
    logic [TICK_WIDTH-1:0] rem_w [NUM_TIMERS];
    logic [TICK_WIDTH-1:0] rld_w [NUM_TIMERS];
    logic [TICK_WIDTH-1:0] acc_w [NUM_TIMERS];

    // Chain of cells; cell zero is the queue head.
    for (genvar i = 0; i < NUM_TIMERS; i++)
    begin : g_cell
        logic                  l_valid, l_cond, l_hole, r_valid;
        logic [DLTQ_ID_W-1:0]  l_id, r_id;
        logic [TICK_WIDTH-1:0] l_rem, l_rld, l_acc, r_rem, r_rld;

        if (i == 0)
        begin : g_first
            assign l_valid = 1'b0;
            assign l_cond  = 1'b0;
            assign l_hole  = 1'b0;
            assign l_id    = '0;
            assign l_rem   = '0;
            assign l_rld   = '0;
            assign l_acc   = '0;
        end
        else
        begin : g_mid
            assign l_valid = valid_vec[i-1];
            assign l_cond  = cond_vec[i-1];
            assign l_hole  = hole_vec[i-1];
            assign l_id    = id_w[i-1];
            assign l_rem   = rem_w[i-1];
            assign l_rld   = rld_w[i-1];
            assign l_acc   = acc_w[i-1];
        end

        if (i == NUM_TIMERS - 1)
        begin : g_end
            assign r_valid = 1'b0;
            assign r_id    = '0;
            assign r_rem   = '0;
            assign r_rld   = '0;
        end
        else
        begin : g_inner
            assign r_valid = valid_vec[i+1];
            assign r_id    = id_w[i+1];
            assign r_rem   = rem_w[i+1];
            assign r_rld   = rld_w[i+1];
        end

        dltq_cell #(.TICK_WIDTH(TICK_WIDTH)) u_cell
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .ins_t       (t_reg),
            .ins_rld     (rld_reg),
            .left_valid  (l_valid),
            .left_cond   (l_cond),
            .left_hole   (l_hole),
            .left_id     (l_id),
            .left_rem    (l_rem),
            .left_rld    (l_rld),
            .left_acc    (l_acc),
            .right_valid (r_valid),
            .right_id    (r_id),
            .right_rem   (r_rem),
            .right_rld   (r_rld),
            .valid       (valid_vec[i]),
            .cond        (cond_vec[i]),
            .hole        (hole_vec[i]),
            .id          (id_w[i]),
            .rem         (rem_w[i]),
            .rld         (rld_w[i]),
            .acc         (acc_w[i])
        );
    end

    assign id_ok = 32'(id_reg) < 32'(NUM_TIMERS);
    assign in_t  = TICK_WIDTH'(in_ch.data.delay);

    // Command sequencer.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        action_next = action_reg;
        id_next     = id_reg;
        t_next      = t_reg;
        rld_next    = rld_reg;
        res_next    = res_reg;
        cmd.op      = OP_NOP;
        cmd.id      = id_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    action_next = in_ch.data.action;
                    id_next     = in_ch.data.timer_id;
                    t_next      = in_t;
                    rld_next    = in_ch.data.repeat_req ? in_t : '0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next              = '0;
                res_next.timer_id_res = id_reg;
                res_next.last         = 1'b1;
                unique case (action_reg)
                    ACT_START:
                    begin
                        if (!id_ok || active_reg[id_reg] || (t_reg == '0))
                        begin
                            res_next.kind = KIND_ERR;
                        end
                        else
                        begin
                            cmd.op              = OP_INSERT;
                            active_next[id_reg] = 1'b1;
                            res_next.kind       = KIND_ACK;
                        end
                        state_next = S_OUT;
                    end
                    ACT_CANCEL:
                    begin
                        res_next.kind = KIND_ACK;
                        if (id_ok && active_reg[id_reg])
                        begin
                            cmd.op              = OP_CANCEL;
                            active_next[id_reg] = 1'b0;
                            cnt_next            = CNT_W'(NUM_TIMERS);
                            state_next          = S_WAIT;
                        end
                        else
                        begin
                            state_next = S_OUT;
                        end
                    end
                    ACT_TICK:
                    begin
                        if (valid_vec[0])
                        begin
                            cmd.op     = OP_DECR;
                            state_next = S_FIRE;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    ACT_QUERY:
                    begin
                        res_next.kind    = KIND_QUERY;
                        res_next.running = id_ok && active_reg[id_reg];
                        cnt_next         = CNT_W'(NUM_TIMERS);
                        state_next       = S_WAIT;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_WAIT:
            begin
                // Compaction and the query answer both settle within one pass.
                cmd.op   = OP_COMPACT;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    if (res_reg.running)
                    begin
                        res_next.remaining = DLTQ_DELAY_W'(acc_w[NUM_TIMERS-1]);
                    end
                    state_next = S_OUT;
                end
            end
            S_FIRE:
            begin
                if (valid_vec[0] && (rem_w[0] == '0))
                begin
                    cmd.op   = OP_POP;
                    id_next  = id_w[0];
                    t_next   = rld_w[0];
                    rld_next = rld_w[0];
                    if (rld_w[0] == '0)
                    begin
                        active_next[id_w[0]] = 1'b0;
                    end
                    state_next = S_REIN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_REIN:
            begin
                if (rld_reg != '0)
                begin
                    cmd.op = OP_INSERT;
                end
                state_next = S_LAST;
            end
            S_LAST:
            begin
                res_next              = '0;
                res_next.kind         = KIND_FIRED;
                res_next.timer_id_res = id_reg;
                res_next.last         = !(valid_vec[0] && (rem_w[0] == '0));
                state_next            = S_OUT;
            end
            S_OUT:
            begin
                if (out_ch.ready)
                begin
                    if ((action_reg == ACT_TICK) && !res_reg.last)
                    begin
                        state_next = S_FIRE;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            active_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        id_reg     <= id_next;
        t_reg      <= t_next;
        rld_reg    <= rld_next;
        res_reg    <= res_next;
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data  = res_reg;

`ifndef SYNTHESIS
    // No hole is left in the chain once a command is finished.
    a_no_hole_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (hole_vec == '0))
        else $error("queue hole left after command");

    // Queued entries and running flags agree between commands.
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(valid_vec) == $countones(active_reg)))
        else $error("queue entry count differs from running timers");

    // The head never waits with zero ticks left.
    a_head_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_IDLE) && valid_vec[0]) |-> (rem_w[0] != '0))
        else $error("expired timer left at queue head");

    // A fired result leaves the block only for a tick.
    a_fired_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && (res_reg.kind == KIND_FIRED)) |-> (action_reg == ACT_TICK))
        else $error("fired result outside a tick");
`endif

endmodule

>>> tb/delta_list_timer_queue_top_tb.sv
// Testbench of the delta-list timer queue: a timer-list predictor and a result scoreboard.
module delta_list_timer_queue_top_tb;
    import dltq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTIM = DEF_NUM_TIMERS;
    localparam int NIL = NTIM;

    // Scoreboard: keeps a predicted timer list and checks results in order.
    class timer_scoreboard;
        logic [31:0] delta_q [NTIM];
        logic [31:0] reload_q [NTIM];
        bit          armed [NTIM];
        int          nxt [NTIM];
        int          prv [NTIM];
        int          head;
        dltq_out_t   pending_results [$];
        int          errors;

        function new();
            head = NIL;
            errors = 0;
            for (int i = 0; i < NTIM; i++)
            begin
                armed[i] = 0;
                nxt[i] = NIL;
                prv[i] = NIL;
                delta_q[i] = '0;
                reload_q[i] = '0;
            end
        endfunction

        // Print one line for a mismatch and count it.
        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function void push_result(logic [1:0] kind, int id, logic [31:0] rem,
                                  logic run, logic lst);
            dltq_out_t r;
            r.kind = kind;
            r.timer_id_res = id[3:0];
            r.remaining = rem;
            r.running = run;
            r.last = lst;
            pending_results.push_back(r);
        endfunction

        // Link a slot into the list in expiry order, ahead of equal expiries.
        function void link_in_order(int s, logic [31:0] t);
            int prior;
            int cur;
            prior = NIL;
            cur = head;
            while (cur != NIL && delta_q[cur] < t)
            begin
                t -= delta_q[cur];
                prior = cur;
                cur = nxt[cur];
            end
            delta_q[s] = t;
            nxt[s] = cur;
            prv[s] = prior;
            if (prior != NIL) nxt[prior] = s;
            else head = s;
            if (cur != NIL)
            begin
                prv[cur] = s;
                delta_q[cur] = delta_q[cur] - t;
            end
            armed[s] = 1;
        endfunction

        function void unlink(int s);
            if (prv[s] != NIL) nxt[prv[s]] = nxt[s];
            else head = nxt[s];
            if (nxt[s] != NIL) prv[nxt[s]] = prv[s];
            nxt[s] = NIL;
            prv[s] = NIL;
            armed[s] = 0;
        endfunction

        // Work out the results of one accepted command.
        function void note_command(dltq_in_t c);
            int s;
            int n;
            int cur;
            logic [31:0] rem;
            s = c.timer_id;
            case (c.action)
                ACT_START:
                begin
                    if (armed[s] || c.delay == 0)
                        push_result(KIND_ERR, s, 0, 0, 1);
                    else
                    begin
                        reload_q[s] = c.repeat_req ? c.delay : 32'd0;
                        link_in_order(s, c.delay);
                        push_result(KIND_ACK, s, 0, 0, 1);
                    end
                end
                ACT_CANCEL:
                begin
                    if (armed[s])
                    begin
                        if (nxt[s] != NIL) delta_q[nxt[s]] += delta_q[s];
                        unlink(s);
                    end
                    push_result(KIND_ACK, s, 0, 0, 1);
                end
                ACT_TICK:
                begin
                    n = 0;
                    cur = head;
                    if (cur != NIL)
                    begin
                        delta_q[cur] -= 1;
                        while (n < NTIM && cur != NIL && delta_q[cur] == 0)
                        begin
                            unlink(cur);
                            if (reload_q[cur] != 0) link_in_order(cur, reload_q[cur]);
                            push_result(KIND_FIRED, cur, 0, 0, 0);
                            n++;
                            cur = head;
                        end
                        if (n > 0) pending_results[$].last = 1;
                    end
                end
                default:
                begin
                    rem = 0;
                    if (armed[s])
                    begin
                        cur = s;
                        while (cur != NIL)
                        begin
                            rem += delta_q[cur];
                            cur = prv[cur];
                        end
                    end
                    push_result(KIND_QUERY, s, rem, armed[s], 1);
                end
            endcase
        endfunction

        task check_result(dltq_out_t got);
            dltq_out_t want;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result %p", got));
                return;
            end
            want = pending_results.pop_front();
            if (got.kind != want.kind) report_mismatch("kind differs");
            if (got.timer_id_res != want.timer_id_res) report_mismatch("timer id differs");
            if (got.remaining != want.remaining) report_mismatch("remaining differs");
            if (got.running != want.running) report_mismatch("running differs");
            if (got.last != want.last) report_mismatch("last differs");
        endtask
    endclass

    logic clk;
    logic rst_n;
    dltq_in_if  in_ch ();
    dltq_out_if out_ch ();

    timer_scoreboard sb;
    bit sink_steady;
    bit hold_sink;
    bit cmd_steady;
    int sink_free_cycles;

    delta_list_timer_queue_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Accepted commands feed the predictor; accepted results are checked.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready) sb.note_command(in_ch.data);
        if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    end

    // Result side: random stalls, a long hold-off when asked, none in the steady stretch.
    always @(negedge clk)
    begin
        if (!rst_n) out_ch.ready <= 1'b0;
        else if (hold_sink) out_ch.ready <= 1'b0;
        else if (sink_steady) out_ch.ready <= 1'b1;
        else out_ch.ready <= ($urandom_range(99) >= 22);
    end

    // Send one command, with random idle cycles ahead of it outside the steady stretch.
    task automatic send_command(logic [1:0] act, int id, logic [31:0] dly, logic rep);
        @(negedge clk);
        if (!cmd_steady)
        begin
            while ($urandom_range(99) < 22)
                @(negedge clk);
        end
        in_ch.data.action <= act;
        in_ch.data.timer_id <= id[3:0];
        in_ch.data.delay <= dly;
        in_ch.data.repeat_req <= rep;
        in_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Mostly short delays so timers fire; occasionally wide ones, and now and then zero.
    function automatic logic [31:0] pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 32'd0;
        if (r < 12) return $urandom;
        return $urandom_range(8, 1);
    endfunction

    initial
    begin
        logic [1:0] act;
        int r;
        sb = new();
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        sink_steady = 0;
        hold_sink = 0;
        cmd_steady = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: every action, field extremes and the special cases.
        send_command(ACT_TICK, 0, 0, 0);
        send_command(ACT_QUERY, 15, 0, 0);
        send_command(ACT_CANCEL, 3, 0, 0);
        send_command(ACT_START, 0, 32'd0, 0);
        send_command(ACT_START, 0, 32'hFFFF_FFFF, 1);
        send_command(ACT_START, 0, 32'd5, 0);
        send_command(ACT_START, 15, 32'd2, 1);
        send_command(ACT_START, 5, 32'd2, 0);
        send_command(ACT_START, 7, 32'd3, 0);
        send_command(ACT_QUERY, 0, 0, 0);
        send_command(ACT_QUERY, 7, 0, 0);
        send_command(ACT_CANCEL, 5, 0, 0);
        send_command(ACT_QUERY, 15, 0, 0);
        send_command(ACT_TICK, 0, 0, 0);
        send_command(ACT_TICK, 9, 0, 1);
        send_command(ACT_TICK, 0, 0, 0);
        send_command(ACT_CANCEL, 15, 0, 0);
        send_command(ACT_CANCEL, 15, 0, 0);
        send_command(ACT_QUERY, 0, 0, 0);
        wait_drained();

        // Fill every slot with a small delay so a single tick fires all of them.
        for (int i = 0; i < NTIM; i++)
            send_command(ACT_START, i, 32'd1, i[0]);
        if (sb.armed[0]) send_command(ACT_CANCEL, 0, 0, 0);
        send_command(ACT_START, 0, 32'd1, 0);
        send_command(ACT_TICK, 0, 0, 0);

        // Pressure: hold the result side off while commands keep coming.
        fork
            begin
                hold_sink = 1;
                repeat (300) @(negedge clk);
                hold_sink = 0;
            end
            begin
                for (int i = 0; i < 6; i++)
                    send_command(ACT_QUERY, i, 0, 0);
            end
        join

        // Random part, with a stretch without idling on either side.
        for (int k = 0; k < 200; k++)
        begin
            sink_steady = (k >= 80 && k < 120);
            cmd_steady = sink_steady;
            r = $urandom_range(99);
            act = (r < 35) ? ACT_START : (r < 50) ? ACT_CANCEL :
                  (r < 85) ? ACT_TICK : ACT_QUERY;
            send_command(act, $urandom_range(15), pick_delay(), $urandom_range(1));
        end
        sink_steady = 0;
        cmd_steady = 0;

        wait_drained();
        repeat (60) @(negedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #5ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
